FILE: design/psk31vt_pkg.sv
// Shared types, constants and the varicode table for the PSK31 varicode transmitter.
package psk31vt_pkg;

    localparam int MSG_DEPTH_DEFAULT = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_TICKS       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_REVERSALS = 2'd1;

    localparam logic [7:0] SYMBOL_TICKS_RST = 8'd32;
    localparam logic [7:0] PREAMBLE_RST     = 8'd8;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_PUSH = 1'b1;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_BUSY = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    // code sent for characters above 127 (space)
    localparam logic [9:0] VC_SPACE = 10'h001;

    typedef enum logic [6:0] {
        ST_DONE     = 7'b0000001,
        ST_INIT     = 7'b0000010,
        ST_PREAMBLE = 7'b0000100,
        ST_SPACE0   = 7'b0001000,
        ST_SPACE1   = 7'b0010000,
        ST_FETCH    = 7'b0100000,
        ST_BITS     = 7'b1000000
    } state_t;

    typedef struct packed {
        logic       phase_bit;
        logic       tx_enable;
        logic       busy;
        logic [1:0] push_status;
    } result_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } mem_wr_t;

    localparam logic [9:0] VC_TABLE [128] = '{
        10'h355, 10'h36d, 10'h2dd, 10'h3bb, 10'h35d, 10'h3eb, 10'h3dd, 10'h2fd,
        10'h3fd, 10'h0f7, 10'h017, 10'h3db, 10'h2ed, 10'h01f, 10'h2bb, 10'h357,
        10'h3bd, 10'h2bd, 10'h2d7, 10'h3d7, 10'h36b, 10'h35b, 10'h2db, 10'h3ab,
        10'h37b, 10'h2fb, 10'h3b7, 10'h2ab, 10'h2eb, 10'h377, 10'h37d, 10'h3fb,
        10'h001, 10'h1ff, 10'h1f5, 10'h15f, 10'h1b7, 10'h2ad, 10'h375, 10'h1fd,
        10'h0df, 10'h0ef, 10'h1ed, 10'h1f7, 10'h057, 10'h02b, 10'h075, 10'h1eb,
        10'h0ed, 10'h0bd, 10'h0b7, 10'h0ff, 10'h1dd, 10'h1b5, 10'h1ad, 10'h16b,
        10'h1ab, 10'h1db, 10'h0af, 10'h17b, 10'h16f, 10'h055, 10'h1d7, 10'h3d5,
        10'h2f5, 10'h05f, 10'h0d7, 10'h0b5, 10'h0ad, 10'h077, 10'h0db, 10'h0bf,
        10'h155, 10'h07f, 10'h17f, 10'h17d, 10'h0eb, 10'h0dd, 10'h0bb, 10'h0d5,
        10'h0ab, 10'h177, 10'h0f5, 10'h07b, 10'h05b, 10'h1d5, 10'h15b, 10'h175,
        10'h15d, 10'h1bd, 10'h2d5, 10'h1df, 10'h1ef, 10'h1bf, 10'h3f5, 10'h16d,
        10'h3ed, 10'h00d, 10'h07d, 10'h03d, 10'h02d, 10'h003, 10'h02f, 10'h06d,
        10'h035, 10'h00b, 10'h1af, 10'h0fd, 10'h01b, 10'h037, 10'h00f, 10'h007,
        10'h03f, 10'h1fb, 10'h015, 10'h01d, 10'h005, 10'h03b, 10'h06f, 10'h06b,
        10'h0fb, 10'h05d, 10'h157, 10'h3b5, 10'h1bb, 10'h2b5, 10'h3ad, 10'h2b7
    };

endpackage

FILE: design/psk31vt_msg_mem.sv
// Message buffer: one write port, one registered read port.
module psk31vt_msg_mem #(
    parameter int MSG_DEPTH = psk31vt_pkg::MSG_DEPTH_DEFAULT,
    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1
) (
    input  logic                 aclk,
    input  psk31vt_pkg::mem_wr_t wr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [AW-1:0]        rd_addr,
    output logic [7:0]           rd_data
);

    logic [7:0] mem [MSG_DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
    end

    // read runs every cycle so the entry at the read pointer is always fresh
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/psk31vt_ctrl.sv
// Send sequencer: tick and push handling, symbol timing and varicode shifting.
module psk31vt_ctrl #(
    parameter int MSG_DEPTH = psk31vt_pkg::MSG_DEPTH_DEFAULT,
    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1,
    localparam int IW = $clog2(MSG_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_en,
    input  logic                 op,
    input  logic [7:0]           char_code,
    input  logic                 char_last,
    input  logic [7:0]           symbol_ticks,
    input  logic [7:0]           preamble_reversals,
    input  logic [7:0]           rd_data,
    output psk31vt_pkg::mem_wr_t mem_wr,
    output logic [AW-1:0]        wr_addr,
    output logic [AW-1:0]        rd_addr,
    output psk31vt_pkg::result_t res
);

    localparam logic [IW-1:0] DEPTH_IDX = IW'(MSG_DEPTH);

    psk31vt_pkg::state_t state_reg, state_next;
    logic [7:0]    timer_reg, timer_next;
    logic [7:0]    pcount_reg, pcount_next;
    logic [9:0]    code_reg, code_next;
    logic          phase_reg, phase_next;
    logic          tx_reg, tx_next;
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [1:0]    status;
    logic [7:0]    fetch_ch;
    logic [7:0]    pcount_dec;

    always_comb begin
        state_next  = state_reg;
        timer_next  = timer_reg;
        pcount_next = pcount_reg;
        code_next   = code_reg;
        phase_next  = phase_reg;
        tx_next     = tx_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        status      = psk31vt_pkg::STATUS_OK;
        mem_wr.en   = 1'b0;
        mem_wr.data = char_code;
        fetch_ch    = (rd_idx_reg < wr_idx_reg) ? rd_data : 8'd0;
        pcount_dec  = pcount_reg - 8'd1;

        if (item_en && op == psk31vt_pkg::OP_PUSH) begin
            if (state_reg != psk31vt_pkg::ST_DONE) begin
                status = psk31vt_pkg::STATUS_BUSY;
            end else begin
                if (wr_idx_reg >= DEPTH_IDX) begin
                    status = psk31vt_pkg::STATUS_FULL;
                end else begin
                    mem_wr.en   = 1'b1;
                    wr_idx_next = wr_idx_reg + IW'(1);
                end
                if (char_last) begin
                    rd_idx_next = '0;
                    timer_next  = 8'd0;
                    state_next  = psk31vt_pkg::ST_INIT;
                end
            end
        end else if (item_en && state_reg != psk31vt_pkg::ST_DONE) begin
            if (timer_reg != 8'd0) begin
                timer_next = timer_reg - 8'd1;
            end else begin
                case (state_reg)
                    psk31vt_pkg::ST_INIT: begin
                        pcount_next = preamble_reversals;
                        tx_next     = 1'b1;
                        state_next  = psk31vt_pkg::ST_PREAMBLE;
                    end
                    psk31vt_pkg::ST_PREAMBLE: begin
                        pcount_next = pcount_dec;
                        if (pcount_dec == 8'd0) begin
                            state_next = psk31vt_pkg::ST_SPACE0;
                        end
                        phase_next = ~phase_reg;
                        timer_next = symbol_ticks;
                    end
                    psk31vt_pkg::ST_SPACE0: begin
                        phase_next = ~phase_reg;
                        timer_next = symbol_ticks;
                        state_next = psk31vt_pkg::ST_SPACE1;
                    end
                    psk31vt_pkg::ST_SPACE1: begin
                        phase_next = ~phase_reg;
                        timer_next = symbol_ticks - 8'd1;
                        state_next = psk31vt_pkg::ST_FETCH;
                    end
                    psk31vt_pkg::ST_FETCH: begin
                        if (fetch_ch == 8'd0) begin
                            tx_next     = 1'b0;
                            state_next  = psk31vt_pkg::ST_DONE;
                            wr_idx_next = '0;
                            rd_idx_next = '0;
                        end else begin
                            code_next  = fetch_ch[7] ? psk31vt_pkg::VC_SPACE
                                                     : psk31vt_pkg::VC_TABLE[fetch_ch[6:0]];
                            state_next = psk31vt_pkg::ST_BITS;
                        end
                    end
                    psk31vt_pkg::ST_BITS: begin
                        timer_next = symbol_ticks;
                        if (code_reg == 10'd0) begin
                            // character done: first of the two gap reversals
                            phase_next  = ~phase_reg;
                            rd_idx_next = rd_idx_reg + IW'(1);
                            state_next  = psk31vt_pkg::ST_SPACE1;
                        end else begin
                            if (!code_reg[0]) begin
                                phase_next = ~phase_reg;
                            end
                            code_next = code_reg >> 1;
                        end
                    end
                    default: begin
                        state_next = psk31vt_pkg::ST_DONE;
                        tx_next    = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= psk31vt_pkg::ST_DONE;
            timer_reg  <= 8'd0;
            pcount_reg <= 8'd0;
            code_reg   <= 10'd0;
            phase_reg  <= 1'b0;
            tx_reg     <= 1'b0;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
        end else begin
            state_reg  <= state_next;
            timer_reg  <= timer_next;
            pcount_reg <= pcount_next;
            code_reg   <= code_next;
            phase_reg  <= phase_next;
            tx_reg     <= tx_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
        end
    end

    assign wr_addr = wr_idx_reg[AW-1:0];
    assign rd_addr = (rd_idx_reg < DEPTH_IDX) ? rd_idx_reg[AW-1:0] : '0;

    assign res.phase_bit   = phase_next;
    assign res.tx_enable   = tx_next;
    assign res.busy        = (state_next != psk31vt_pkg::ST_DONE);
    assign res.push_status = status;

endmodule

FILE: design/psk31_varicode_transmitter_core.sv
// Top level of the PSK31 varicode transmitter: handshakes, registers, result register.
//
// Input channel (s_valid/s_ready): each item is either a 1 ms tick (s_op = 0)
// or a message character push (s_op = 1, s_char_code, s_char_last). While
// idle, pushes fill the message buffer; a push with s_char_last starts a send.
// Result channel (m_valid/m_ready): exactly one result per input item, giving
// the carrier phase, transmit enable, busy flag and push status after that
// item has been applied.
// The result of an item accepted at one edge is registered and is valid after
// that edge. Throughput is one item per cycle while the receiver takes results,
// limited by the single result register; the message buffer is read through a
// registered port that tracks the read pointer every cycle.
// When the receiver stalls, the result register holds its item and s_ready
// drops until that item is taken; no item is lost.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is symbol_ticks, index 1 is preamble_reversals, others are ignored.
// Reset (aresetn low, synchronous) returns the sequencer to idle, empties the
// buffer, clears the phase and loads the default register values.
module psk31_varicode_transmitter_core #(
    parameter int MSG_DEPTH = psk31vt_pkg::MSG_DEPTH_DEFAULT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_op,
    input  logic [7:0]                        s_char_code,
    input  logic                              s_char_last,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_phase_bit,
    output logic                              m_tx_enable,
    output logic                              m_busy_res,
    output logic [1:0]                        m_push_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psk31vt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data
);

    localparam int AW = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;

    logic [7:0]           symbol_ticks_reg;
    logic [7:0]           preamble_reg;
    logic                 m_valid_reg;
    psk31vt_pkg::result_t res_reg;
    psk31vt_pkg::result_t res;
    psk31vt_pkg::mem_wr_t mem_wr;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [7:0]           rd_data;
    logic                 item_en;

    assign s_ready   = !m_valid_reg || m_ready;
    assign item_en   = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            symbol_ticks_reg <= psk31vt_pkg::SYMBOL_TICKS_RST;
            preamble_reg     <= psk31vt_pkg::PREAMBLE_RST;
        end else if (cfg_valid) begin
            if (cfg_index == psk31vt_pkg::CFG_SYMBOL_TICKS) begin
                symbol_ticks_reg <= cfg_data;
            end else if (cfg_index == psk31vt_pkg::CFG_PREAMBLE_REVERSALS) begin
                preamble_reg <= cfg_data;
            end
        end
    end

    psk31vt_ctrl #(
        .MSG_DEPTH(MSG_DEPTH)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .item_en           (item_en),
        .op                (s_op),
        .char_code         (s_char_code),
        .char_last         (s_char_last),
        .symbol_ticks      (symbol_ticks_reg),
        .preamble_reversals(preamble_reg),
        .rd_data           (rd_data),
        .mem_wr            (mem_wr),
        .wr_addr           (wr_addr),
        .rd_addr           (rd_addr),
        .res               (res)
    );

    psk31vt_msg_mem #(
        .MSG_DEPTH(MSG_DEPTH)
    ) u_msg_mem (
        .aclk   (aclk),
        .wr     (mem_wr),
        .wr_addr(wr_addr),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_en) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_phase_bit   = res_reg.phase_bit;
    assign m_tx_enable   = res_reg.tx_enable;
    assign m_busy_res    = res_reg.busy;
    assign m_push_status = res_reg.push_status;

    // transmitter is only keyed during a send
    a_tx_implies_busy: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.tx_enable |-> res_reg.busy
    ) else $error("tx_enable without busy");

    // a push rejected as busy leaves the send running
    a_busy_reject: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg && res_reg.push_status == psk31vt_pkg::STATUS_BUSY |-> res_reg.busy
    ) else $error("busy rejection while idle");

    // the buffer is written only by an accepted push
    a_write_on_push: assert property (
        @(posedge aclk) disable iff (!aresetn)
        mem_wr.en |-> item_en && s_op == psk31vt_pkg::OP_PUSH
    ) else $error("buffer write without push");

endmodule

FILE: dv/psk31vt_checker.sv
// Channel monitor, line-state predictor and result comparison for the PSK31 transmitter.
module psk31vt_checker #(
    parameter int MSG_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              s_op,
    input  logic [7:0]                        s_char_code,
    input  logic                              s_char_last,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic                              m_phase_bit,
    input  logic                              m_tx_enable,
    input  logic                              m_busy_res,
    input  logic [1:0]                        m_push_status,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [psk31vt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                        cfg_data,
    output int                                n_fail,
    output int                                n_pending,
    output bit                                send_active
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] DEF_SYMBOL_TICKS = 8'd32;
    localparam logic [7:0] DEF_PREAMBLE     = 8'd8;
    localparam logic [9:0] SPACE_VARICODE   = 10'h001;

    localparam logic [9:0] VARICODE [128] = '{
        10'h355, 10'h36d, 10'h2dd, 10'h3bb, 10'h35d, 10'h3eb, 10'h3dd, 10'h2fd,
        10'h3fd, 10'h0f7, 10'h017, 10'h3db, 10'h2ed, 10'h01f, 10'h2bb, 10'h357,
        10'h3bd, 10'h2bd, 10'h2d7, 10'h3d7, 10'h36b, 10'h35b, 10'h2db, 10'h3ab,
        10'h37b, 10'h2fb, 10'h3b7, 10'h2ab, 10'h2eb, 10'h377, 10'h37d, 10'h3fb,
        10'h001, 10'h1ff, 10'h1f5, 10'h15f, 10'h1b7, 10'h2ad, 10'h375, 10'h1fd,
        10'h0df, 10'h0ef, 10'h1ed, 10'h1f7, 10'h057, 10'h02b, 10'h075, 10'h1eb,
        10'h0ed, 10'h0bd, 10'h0b7, 10'h0ff, 10'h1dd, 10'h1b5, 10'h1ad, 10'h16b,
        10'h1ab, 10'h1db, 10'h0af, 10'h17b, 10'h16f, 10'h055, 10'h1d7, 10'h3d5,
        10'h2f5, 10'h05f, 10'h0d7, 10'h0b5, 10'h0ad, 10'h077, 10'h0db, 10'h0bf,
        10'h155, 10'h07f, 10'h17f, 10'h17d, 10'h0eb, 10'h0dd, 10'h0bb, 10'h0d5,
        10'h0ab, 10'h177, 10'h0f5, 10'h07b, 10'h05b, 10'h1d5, 10'h15b, 10'h175,
        10'h15d, 10'h1bd, 10'h2d5, 10'h1df, 10'h1ef, 10'h1bf, 10'h3f5, 10'h16d,
        10'h3ed, 10'h00d, 10'h07d, 10'h03d, 10'h02d, 10'h003, 10'h02f, 10'h06d,
        10'h035, 10'h00b, 10'h1af, 10'h0fd, 10'h01b, 10'h037, 10'h00f, 10'h007,
        10'h03f, 10'h1fb, 10'h015, 10'h01d, 10'h005, 10'h03b, 10'h06f, 10'h06b,
        10'h0fb, 10'h05d, 10'h157, 10'h3b5, 10'h1bb, 10'h2b5, 10'h3ad, 10'h2b7
    };

    // predicted block state
    logic [7:0]          sym_ticks;
    logic [7:0]          pre_revs;
    psk31vt_pkg::state_t fsm;
    logic [7:0]          sym_timer;
    logic [7:0]          pre_count;
    logic [9:0]          code_sr;
    logic                phase;
    logic                keyed;
    logic [7:0]          msg_mem [MSG_DEPTH];
    int unsigned         wr_ptr;
    int unsigned         rd_ptr;

    psk31vt_pkg::result_t line_state_q [$];
    int                   errs = 0;

    task automatic clear_tx_state();
        sym_ticks = DEF_SYMBOL_TICKS;
        pre_revs  = DEF_PREAMBLE;
        fsm       = psk31vt_pkg::ST_DONE;
        sym_timer = '0;
        pre_count = '0;
        code_sr   = '0;
        phase     = 1'b0;
        keyed     = 1'b0;
        wr_ptr    = 0;
        rd_ptr    = 0;
    endtask

    task automatic advance_tick();
        logic [7:0] ch;
        ch = 8'h00;
        if (fsm != psk31vt_pkg::ST_DONE) begin
            if (sym_timer != 8'd0) begin
                sym_timer = sym_timer - 8'd1;
            end else begin
                case (fsm)
                    psk31vt_pkg::ST_INIT: begin
                        pre_count = pre_revs;
                        keyed     = 1'b1;
                        fsm       = psk31vt_pkg::ST_PREAMBLE;
                    end
                    psk31vt_pkg::ST_PREAMBLE: begin
                        // a zero count wraps, giving 256 reversals
                        pre_count = pre_count - 8'd1;
                        if (pre_count == 8'd0)
                            fsm = psk31vt_pkg::ST_SPACE0;
                        phase     = ~phase;
                        sym_timer = sym_ticks;
                    end
                    psk31vt_pkg::ST_SPACE0: begin
                        phase     = ~phase;
                        sym_timer = sym_ticks;
                        fsm       = psk31vt_pkg::ST_SPACE1;
                    end
                    psk31vt_pkg::ST_SPACE1: begin
                        phase     = ~phase;
                        sym_timer = sym_ticks - 8'd1;
                        fsm       = psk31vt_pkg::ST_FETCH;
                    end
                    psk31vt_pkg::ST_FETCH: begin
                        if (rd_ptr < wr_ptr && rd_ptr < MSG_DEPTH)
                            ch = msg_mem[rd_ptr];
                        if (ch == 8'h00) begin
                            keyed  = 1'b0;
                            fsm    = psk31vt_pkg::ST_DONE;
                            wr_ptr = 0;
                            rd_ptr = 0;
                        end else begin
                            code_sr = ch[7] ? SPACE_VARICODE : VARICODE[ch[6:0]];
                            fsm     = psk31vt_pkg::ST_BITS;
                        end
                    end
                    psk31vt_pkg::ST_BITS: begin
                        if (code_sr == 10'd0) begin
                            phase     = ~phase;
                            sym_timer = sym_ticks;
                            rd_ptr++;
                            fsm       = psk31vt_pkg::ST_SPACE1;
                        end else begin
                            if (!code_sr[0])
                                phase = ~phase;
                            code_sr   = code_sr >> 1;
                            sym_timer = sym_ticks;
                        end
                    end
                    default: begin
                        fsm   = psk31vt_pkg::ST_DONE;
                        keyed = 1'b0;
                    end
                endcase
            end
        end
    endtask

    task automatic store_char(input logic [7:0] ch, input logic last, output logic [1:0] status);
        status = psk31vt_pkg::STATUS_OK;
        if (fsm != psk31vt_pkg::ST_DONE) begin
            status = psk31vt_pkg::STATUS_BUSY;
        end else begin
            if (wr_ptr >= MSG_DEPTH) begin
                status = psk31vt_pkg::STATUS_FULL;
            end else begin
                msg_mem[wr_ptr] = ch;
                wr_ptr++;
            end
            // a full buffer still starts the send on the last push
            if (last) begin
                rd_ptr    = 0;
                sym_timer = 8'd0;
                fsm       = psk31vt_pkg::ST_INIT;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errs++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        psk31vt_pkg::result_t want;
        logic [1:0]           status;
        if (!aresetn) begin
            clear_tx_state();
            line_state_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (line_state_q.size() == 0) begin
                    $error("result with no item waiting: phase_bit %0b tx_enable %0b",
                           m_phase_bit, m_tx_enable);
                    errs++;
                end else begin
                    want = line_state_q.pop_front();
                    check_field("phase_bit", 2'(want.phase_bit), 2'(m_phase_bit));
                    check_field("tx_enable", 2'(want.tx_enable), 2'(m_tx_enable));
                    check_field("busy_res", 2'(want.busy), 2'(m_busy_res));
                    check_field("push_status", want.push_status, m_push_status);
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == psk31vt_pkg::CFG_SYMBOL_TICKS)
                    sym_ticks = cfg_data;
                else if (cfg_index == psk31vt_pkg::CFG_PREAMBLE_REVERSALS)
                    pre_revs = cfg_data;
            end
            if (s_valid && s_ready) begin
                status = psk31vt_pkg::STATUS_OK;
                if (s_op == psk31vt_pkg::OP_TICK)
                    advance_tick();
                else
                    store_char(s_char_code, s_char_last, status);
                want.phase_bit   = phase;
                want.tx_enable   = keyed;
                want.busy        = (fsm != psk31vt_pkg::ST_DONE);
                want.push_status = status;
                line_state_q.push_back(want);
            end
        end
        n_pending   <= line_state_q.size();
        n_fail      <= errs;
        send_active <= (fsm != psk31vt_pkg::ST_DONE);
    end

endmodule

FILE: dv/tb_psk31_varicode_transmitter_core.sv
// Stimulus, clock, reset and verdict for the PSK31 varicode transmitter core.
module tb_psk31_varicode_transmitter_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MSG_DEPTH       = 64;
    localparam int RAND_ITEMS      = 250;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam logic [psk31vt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_op;
    logic [7:0]                        s_char_code;
    logic                              s_char_last;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_phase_bit;
    logic                              m_tx_enable;
    logic                              m_busy_res;
    logic [1:0]                        m_push_status;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [psk31vt_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                        cfg_data;

    int          n_fail;
    int          n_pending;
    bit          send_active;
    int          src_idle_pct;
    int          snk_idle_pct;
    bit          hold_go;
    int unsigned items_sent;

    psk31_varicode_transmitter_core #(
        .MSG_DEPTH(MSG_DEPTH)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_char_code  (s_char_code),
        .s_char_last  (s_char_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_phase_bit  (m_phase_bit),
        .m_tx_enable  (m_tx_enable),
        .m_busy_res   (m_busy_res),
        .m_push_status(m_push_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    psk31vt_checker #(
        .MSG_DEPTH(MSG_DEPTH)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_char_code  (s_char_code),
        .s_char_last  (s_char_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_phase_bit  (m_phase_bit),
        .m_tx_enable  (m_tx_enable),
        .m_busy_res   (m_busy_res),
        .m_push_status(m_push_status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .n_fail       (n_fail),
        .n_pending    (n_pending),
        .send_active  (send_active)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : sink
        bit held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_item(input logic op, input logic [7:0] code, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_char_code <= code;
        s_char_last <= last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        items_sent++;
    endtask

    task automatic send_tick();
        // code and last are don't-care on a tick, so they get noise
        send_item(psk31vt_pkg::OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // keep ticking until the send is over; a few pushes hit the busy block
    task automatic tick_until_idle();
        do begin
            if ($urandom_range(99) < 3)
                send_item(psk31vt_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b0);
            else
                send_tick();
        end while (send_active);
    endtask

    task automatic drain_items();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [7:0] ticks, input logic [7:0] pre,
                                input bit spare);
        drain_items();
        cfg_valid <= 1'b1;
        cfg_index <= psk31vt_pkg::CFG_SYMBOL_TICKS;
        cfg_data  <= ticks;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_index <= psk31vt_pkg::CFG_PREAMBLE_REVERSALS;
        cfg_data  <= pre;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        if (spare) begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= 8'($urandom_range(255));
            do @(posedge aclk); while (cfg_ready !== 1'b1);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int src_pct, input int snk_pct);
        src_idle_pct <= src_pct;
        snk_idle_pct <= snk_pct;
    endtask

    initial begin : stimulus
        int          n;
        int          r;
        int unsigned rand_base;
        int unsigned done_items;
        bit          pressed;
        bit          do_msg;
        logic [7:0]  ch;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_op         = psk31vt_pkg::OP_TICK;
        s_char_code  = 8'h00;
        s_char_last  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = psk31vt_pkg::CFG_SYMBOL_TICKS;
        cfg_data     = 8'h00;
        hold_go      = 1'b0;
        src_idle_pct = 28;
        snk_idle_pct = 73;
        items_sent   = 0;
        pressed      = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: idle tick, then a lone zero character (preamble and gap only)
        send_tick();
        send_item(psk31vt_pkg::OP_PUSH, 8'h00, 1'b1);
        tick_until_idle();

        program_regs(8'd1, 8'd1, 1'b1);
        // highest table entry, a code above 127, then a zero that cuts the message
        send_item(psk31vt_pkg::OP_PUSH, 8'h7F, 1'b0);
        send_item(psk31vt_pkg::OP_PUSH, 8'hFF, 1'b0);
        send_item(psk31vt_pkg::OP_PUSH, 8'h00, 1'b0);
        send_item(psk31vt_pkg::OP_PUSH, 8'h41, 1'b1);
        repeat (12) send_tick();
        send_item(psk31vt_pkg::OP_PUSH, 8'h33, 1'b1);
        send_item(psk31vt_pkg::OP_PUSH, 8'h80, 1'b0);
        tick_until_idle();

        // fill the buffer, overflow once plain and once with last;
        // an early zero keeps the send short
        for (int i = 0; i < MSG_DEPTH; i++) begin
            ch = (i == 7) ? 8'h00 : 8'($urandom_range(1, 255));
            send_item(psk31vt_pkg::OP_PUSH, ch, 1'b0);
        end
        send_item(psk31vt_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b0);
        send_item(psk31vt_pkg::OP_PUSH, 8'($urandom_range(255)), 1'b1);
        tick_until_idle();

        // zero registers: 256 reversals and a wrapped reload before the fetch
        program_regs(8'd0, 8'd0, 1'b0);
        send_item(psk31vt_pkg::OP_PUSH, 8'h00, 1'b1);
        tick_until_idle();

        program_regs(8'd1, 8'd2, 1'b0);
        rand_base = items_sent;
        done_items = 0;
        while (done_items < RAND_ITEMS) begin
            if (done_items >= (2 * RAND_ITEMS) / 3)
                set_idle(0, 0);
            else if (done_items >= RAND_ITEMS / 3)
                set_idle(73, 28);
            else
                set_idle(28, 73);

            if ($urandom_range(3) == 0)
                program_regs(($urandom_range(7) == 0) ? 8'($urandom_range(3, 9))
                                                      : 8'($urandom_range(1, 2)),
                             8'($urandom_range(1, 4)), ($urandom_range(7) == 0));

            do_msg = ($urandom_range(9) < 7) ||
                     (!pressed && done_items > (5 * RAND_ITEMS) / 6);
            if (do_msg) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    if ($urandom_range(4) == 0)
                        send_tick();
                    r = $urandom_range(99);
                    if (r < 8)
                        ch = 8'h00;
                    else if (r < 28)
                        ch = 8'($urandom_range(128, 255));
                    else
                        ch = 8'($urandom_range(1, 127));
                    send_item(psk31vt_pkg::OP_PUSH, ch, (i == n - 1));
                end
                if (!pressed && done_items > (5 * RAND_ITEMS) / 6) begin
                    // results back up while ticks keep coming
                    hold_go <= 1'b1;
                    pressed = 1'b1;
                end
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
            tick_until_idle();
            done_items = items_sent - rand_base;
        end

        drain_items();
        repeat (8) @(posedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
design/psk31vt_pkg.sv
design/psk31vt_msg_mem.sv
design/psk31vt_ctrl.sv
design/psk31_varicode_transmitter_core.sv
dv/psk31vt_checker.sv
dv/tb_psk31_varicode_transmitter_core.sv
